[rtl/slfp_pkg.sv]
// shared types, constants and helpers for the status led flicker/pulse controller
// no dependencies
`default_nettype none

package slfp_pkg;

    // timestamp arithmetic width, elapsed time wraps at 2^TIME_W
    localparam int TIME_W = 32;
    // width of the elapsed-time compares, covers both timestamp and 32-bit resync time
    localparam int CMP_W  = (TIME_W > 32) ? TIME_W : 32;

    localparam int NOW_W   = 32;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int SHORT_W = 16;
    localparam int CODE_W  = 3;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_FLICKER_ON  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_FLICKER_OFF = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SHORT_PULSE = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LONG_PULSE  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RESYNC      = 3'd4;

    // reset values
    localparam logic [SHORT_W-1:0] RST_FLICKER_ON  = 16'd10;
    localparam logic [SHORT_W-1:0] RST_FLICKER_OFF = 16'd90;
    localparam logic [SHORT_W-1:0] RST_SHORT_PULSE = 16'd500;
    localparam logic [SHORT_W-1:0] RST_LONG_PULSE  = 16'd1000;
    localparam logic [CFG_W-1:0]   RST_RESYNC      = 32'd10000;

    // item kinds
    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // mode codes as seen on the ports
    localparam logic [CODE_W-1:0] CODE_OFF     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ON      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FLICKER = 3'd2;
    localparam logic [CODE_W-1:0] CODE_SHORT   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_LONG    = 3'd4;
    localparam logic [CODE_W-1:0] CODE_UNSET   = 3'd5;

    typedef enum logic [5:0] {
        MODE_OFF     = 6'b000001,
        MODE_ON      = 6'b000010,
        MODE_FLICKER = 6'b000100,
        MODE_SHORT   = 6'b001000,
        MODE_LONG    = 6'b010000,
        MODE_UNSET   = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [SHORT_W-1:0] flicker_on;
        logic [SHORT_W-1:0] flicker_off;
        logic [SHORT_W-1:0] short_pulse;
        logic [SHORT_W-1:0] long_pulse;
        logic [CFG_W-1:0]   resync;
    } cfg_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        case (m)
            MODE_OFF:     c = CODE_OFF;
            MODE_ON:      c = CODE_ON;
            MODE_FLICKER: c = CODE_FLICKER;
            MODE_SHORT:   c = CODE_SHORT;
            MODE_LONG:    c = CODE_LONG;
            default:      c = CODE_UNSET;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/slfp_cfg_regs.sv]
// configuration registers: flicker times, pulse durations and resync time
// depends on slfp_pkg
`default_nettype none

module slfp_cfg_regs (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [slfp_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [slfp_pkg::CFG_W-1:0]  cfg_wdata,
    output slfp_pkg::cfg_t                cfg
);
    import slfp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flicker_on  <= RST_FLICKER_ON;
            cfg_reg.flicker_off <= RST_FLICKER_OFF;
            cfg_reg.short_pulse <= RST_SHORT_PULSE;
            cfg_reg.long_pulse  <= RST_LONG_PULSE;
            cfg_reg.resync      <= RST_RESYNC;
        end
        else if (cfg_we)
        begin
            // writes beyond the register list are dropped
            case (cfg_addr)
                REG_FLICKER_ON:  cfg_reg.flicker_on  <= cfg_wdata[SHORT_W-1:0];
                REG_FLICKER_OFF: cfg_reg.flicker_off <= cfg_wdata[SHORT_W-1:0];
                REG_SHORT_PULSE: cfg_reg.short_pulse <= cfg_wdata[SHORT_W-1:0];
                REG_LONG_PULSE:  cfg_reg.long_pulse  <= cfg_wdata[SHORT_W-1:0];
                REG_RESYNC:      cfg_reg.resync      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/slfp_step.sv]
// led mode state and per-item next-state logic
// depends on slfp_pkg
`default_nettype none

module slfp_step (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      req_type,
    input  wire logic [slfp_pkg::CODE_W-1:0] mode_req,
    input  wire logic [slfp_pkg::NOW_W-1:0]  now_ms,
    input  wire slfp_pkg::cfg_t            cfg,
    output logic                           led_on,
    output logic                           led_driven,
    output logic [slfp_pkg::CODE_W-1:0]    mode_now
);
    import slfp_pkg::*;

    mode_t             mode_reg,  mode_next;
    logic              red_reg,   red_next;
    logic [TIME_W-1:0] stamp_reg, stamp_next;
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] elapsed;
    logic [CMP_W-1:0]  el_c;
    logic [CMP_W-1:0]  pulse_len;
    logic              drv;

    assign now_t   = TIME_W'(now_ms);
    assign elapsed = now_t - stamp_reg;
    assign el_c    = CMP_W'(elapsed);
    assign pulse_len = (mode_reg == MODE_SHORT) ? CMP_W'(cfg.short_pulse)
                                                : CMP_W'(cfg.long_pulse);

    always_comb
    begin
        mode_next  = mode_reg;
        red_next   = red_reg;
        stamp_next = stamp_reg;
        drv        = 1'b0;
        if (req_type == REQ_SET)
        begin
            case (mode_req)
                CODE_OFF:
                begin
                    // off is ignored while already off or during a pulse
                    if (mode_reg != MODE_OFF && mode_reg != MODE_SHORT &&
                        mode_reg != MODE_LONG)
                    begin
                        red_next  = 1'b0;
                        drv       = 1'b1;
                        mode_next = MODE_OFF;
                    end
                end
                CODE_FLICKER:
                begin
                    if (el_c > CMP_W'(cfg.resync))
                        stamp_next = now_t;
                    mode_next = MODE_FLICKER;
                end
                CODE_SHORT, CODE_LONG:
                begin
                    red_next   = 1'b1;
                    drv        = 1'b1;
                    stamp_next = now_t;
                    mode_next  = (mode_req == CODE_SHORT) ? MODE_SHORT : MODE_LONG;
                end
                default:
                begin
                    // on, and the unused request codes behave as on
                    if (mode_reg != MODE_ON)
                    begin
                        red_next  = 1'b1;
                        drv       = 1'b1;
                        mode_next = MODE_ON;
                    end
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_FLICKER:
                begin
                    if (red_reg && el_c > CMP_W'(cfg.flicker_on))
                    begin
                        red_next   = 1'b0;
                        drv        = 1'b1;
                        stamp_next = now_t;
                    end
                    else if (!red_reg && el_c > CMP_W'(cfg.flicker_off))
                    begin
                        red_next   = 1'b1;
                        drv        = 1'b1;
                        stamp_next = now_t;
                    end
                end
                MODE_SHORT, MODE_LONG:
                begin
                    if (el_c > pulse_len)
                    begin
                        red_next  = 1'b0;
                        drv       = 1'b1;
                        mode_next = MODE_OFF;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_UNSET;
            red_reg   <= 1'b0;
            stamp_reg <= '0;
        end
        else if (en)
        begin
            mode_reg  <= mode_next;
            red_reg   <= red_next;
            stamp_reg <= stamp_next;
        end
    end

    assign led_on     = red_next;
    assign led_driven = drv;
    assign mode_now   = mode_code(mode_next);

    // a short pulse request always lands in short pulse mode with the led lit
    a_pulse_enters: assert property (@(posedge clk) disable iff (!rst_n)
        en && req_type == REQ_SET && mode_req == CODE_SHORT
        |=> mode_reg == MODE_SHORT && red_reg)
        else $error("short pulse request did not start a pulse");

    // an item that issues no drive leaves the led level alone
    a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        en && !drv |=> red_reg == $past(red_reg))
        else $error("led level changed without a drive");

    // a run check outside flicker never moves the timestamp
    a_stamp_flicker_only: assert property (@(posedge clk) disable iff (!rst_n)
        en && req_type == REQ_CHECK && mode_reg != MODE_FLICKER |=> $stable(stamp_reg))
        else $error("timestamp moved on a run check outside flicker");

    // a pulse that ends falls back to off with the led dark
    a_pulse_ends_off: assert property (@(posedge clk) disable iff (!rst_n)
        en && req_type == REQ_CHECK && (mode_reg == MODE_SHORT || mode_reg == MODE_LONG)
        && drv |=> mode_reg == MODE_OFF && !red_reg)
        else $error("pulse end did not return to off");

endmodule

`default_nettype wire

[rtl/status_led_flicker_pulse_ctrl_core.sv]
// top level of the status led flicker/pulse controller: input register, result register
// depends on slfp_pkg, slfp_cfg_regs, slfp_step
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------
//   in      | in_valid / in_ready | req_type, mode_req, now_ms
//   out     | out_valid/out_ready | led_on, led_driven, mode_now
//   cfg     | cfg_we (no wait)    | cfg_addr, cfg_wdata
//
// one item per cycle sustained while out_ready is high; an item passes from acceptance
// through the input register, then through the mode logic into the result register.
// reset clears the mode to unset, the led to off, the timestamp to zero, config to defaults.
// a stalled result holds the pipe; in_ready follows out_ready combinationally.
`default_nettype none

module status_led_flicker_pulse_ctrl_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         req_type,
    input  wire logic [slfp_pkg::CODE_W-1:0]  mode_req,
    input  wire logic [slfp_pkg::NOW_W-1:0]   now_ms,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              led_on,
    output logic                              led_driven,
    output logic [slfp_pkg::CODE_W-1:0]       mode_now,
    input  wire logic                         cfg_we,
    input  wire logic [slfp_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic [slfp_pkg::CFG_W-1:0]   cfg_wdata
);
    import slfp_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic              req_type_reg;
    logic [CODE_W-1:0] mode_req_reg;
    logic [NOW_W-1:0]  now_reg;
    logic              out_valid_reg;
    logic              led_on_reg;
    logic              led_driven_reg;
    logic [CODE_W-1:0] mode_now_reg;
    logic              advance;
    logic              led_on_next;
    logic              led_driven_next;
    logic [CODE_W-1:0] mode_now_next;

    // item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    slfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slfp_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .req_type   (req_type_reg),
        .mode_req   (mode_req_reg),
        .now_ms     (now_reg),
        .cfg        (cfg),
        .led_on     (led_on_next),
        .led_driven (led_driven_next),
        .mode_now   (mode_now_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= req_type;
            mode_req_reg <= mode_req;
            now_reg      <= now_ms;
        end
        if (advance)
        begin
            led_on_reg     <= led_on_next;
            led_driven_reg <= led_driven_next;
            mode_now_reg   <= mode_now_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign led_on     = led_on_reg;
    assign led_driven = led_driven_reg;
    assign mode_now   = mode_now_reg;

endmodule

`default_nettype wire
